// File: rtl/prd_pkg.sv
`timescale 1ns / 1ps

package prd_pkg;

  // Global file header and per-record header sizes in bytes.
  localparam logic [4:0] GLOBAL_HDR_LEN = 5'd24;
  localparam logic [4:0] RECORD_HDR_LEN = 5'd16;
  localparam logic [4:0] MAGIC_LEN      = 5'd4;

  // Microseconds in one second.
  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;

  // Little-endian pcap magic, in file order.
  localparam logic [7:0] MAGIC [4] = '{8'hd4, 8'hc3, 8'hb2, 8'ha1};

  // End-of-file status codes.
  typedef enum logic [1:0] {
    ST_NONE      = 2'd0,
    ST_CLEAN_END = 2'd1,
    ST_NOT_PCAP  = 2'd2,
    ST_TRUNCATED = 2'd3
  } status_t;

  // One result beat.
  typedef struct packed {
    logic [7:0]  data;
    logic        data_valid;
    logic        packet_first;
    logic        packet_last;
    logic [51:0] timestamp_us;
    logic [32:0] record_len;
    status_t     status;
  } result_t;

endpackage

// File: rtl/pcap_record_deframer.sv
`timescale 1ns / 1ps

// Channel   Handshake             Payload
// input     in_valid / in_ready   file_byte, file_end
// output    out_valid / out_ready data, data_valid, packet_first, packet_last,
//                                 timestamp_us, record_len, status
// config    cfg_wr_en             cfg_wr_data (include_header)
//
// One file byte is taken every clock while in_ready is high; its result beat, if
// any, is registered in the output register or the skid entry. The parser is a
// single register stage; the seconds-to-microseconds product has its own register.
// in_ready drops only while the skid entry holds a beat behind a stalled output.
// Reset (rst, synchronous) clears the parser, the buffer and include_header.

module pcap_record_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  file_byte,
  input  logic        file_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  data,
  output logic        data_valid,
  output logic        packet_first,
  output logic        packet_last,
  output logic [51:0] timestamp_us,
  output logic [32:0] record_len,
  output logic [1:0]  status
);
  import prd_pkg::*;

  logic    in_accept;
  logic    res_have;
  result_t res;
  result_t out_data;

  assign in_accept = in_valid && in_ready;

  // Byte parser.
  prd_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_accept   (in_accept),
    .file_byte   (file_byte),
    .file_end    (file_end),
    .res_have    (res_have),
    .res         (res)
  );

  // Result register and skid entry.
  prd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (in_accept && res_have),
    .push_data (res),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign data         = out_data.data;
  assign data_valid   = out_data.data_valid;
  assign packet_first = out_data.packet_first;
  assign packet_last  = out_data.packet_last;
  assign timestamp_us = out_data.timestamp_us;
  assign record_len   = out_data.record_len;
  assign status       = out_data.status;

endmodule

// File: rtl/prd_parse.sv
`timescale 1ns / 1ps

module prd_parse (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic              cfg_wr_data,
  input  logic              in_accept,
  input  logic [7:0]        file_byte,
  input  logic              file_end,
  output logic              res_have,
  output prd_pkg::result_t  res
);
  import prd_pkg::*;

  typedef enum logic [1:0] {
    PH_GLOBAL,
    PH_RECHDR,
    PH_DATA,
    PH_REJECT
  } phase_t;

  phase_t      phase, phase_next;
  logic [4:0]  header_count, header_count_next;
  logic [31:0] seconds, seconds_next;
  logic [31:0] microseconds, microseconds_next;
  logic [31:0] captured_length, captured_length_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic        hdr_latched, hdr_latched_next;
  logic        include_header;
  logic [51:0] seconds_us;
  logic        hdr_eff;
  logic [4:0]  lane;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      include_header <= 1'b0;
    end else if (cfg_wr_en) begin
      include_header <= cfg_wr_data;
    end
  end

  // Seconds scaled to microseconds. The seconds field is complete on the fourth
  // header byte, before any record ends, so the product is always settled when used.
  always_ff @(posedge clk) begin
    seconds_us <= {20'd0, seconds} * {32'd0, USEC_PER_SEC};
  end

  assign lane = {header_count[1:0], 3'b000};

  // Next state and result for the beat at the input.
  always_comb begin
    phase_next           = phase;
    header_count_next    = header_count;
    seconds_next         = seconds;
    microseconds_next    = microseconds;
    captured_length_next = captured_length;
    bytes_left_next      = bytes_left;
    hdr_latched_next     = hdr_latched;
    hdr_eff              = hdr_latched;
    res_have             = 1'b0;
    res                  = '0;

    unique case (phase)
      PH_GLOBAL: begin
        if (header_count < MAGIC_LEN && file_byte != MAGIC[header_count[1:0]]) begin
          phase_next = PH_REJECT;
        end else if (header_count == GLOBAL_HDR_LEN - 5'd1) begin
          phase_next        = PH_RECHDR;
          header_count_next = '0;
        end else begin
          header_count_next = header_count + 5'd1;
        end
      end
      PH_RECHDR: begin
        // The header option is sampled on the first header byte.
        if (header_count == '0) begin
          hdr_eff              = include_header;
          hdr_latched_next     = include_header;
          seconds_next         = '0;
          microseconds_next    = '0;
          captured_length_next = '0;
        end
        case (header_count[3:2])
          2'd0:    seconds_next[lane +: 8] = file_byte;
          2'd1:    microseconds_next[lane +: 8] = file_byte;
          2'd2:    captured_length_next[lane +: 8] = file_byte;
          default: ;
        endcase
        if (hdr_eff) begin
          res_have         = 1'b1;
          res.data_valid   = 1'b1;
          res.data         = file_byte;
          res.packet_first = (header_count == '0);
        end
        if (header_count == RECORD_HDR_LEN - 5'd1) begin
          header_count_next = '0;
          if (captured_length == '0) begin
            // Empty record: it ends on its last header byte.
            res_have        = 1'b1;
            res.packet_last = 1'b1;
            if (!hdr_eff) begin
              res.packet_first = 1'b1;
            end
          end else begin
            phase_next      = PH_DATA;
            bytes_left_next = captured_length;
          end
        end else begin
          header_count_next = header_count + 5'd1;
        end
      end
      PH_DATA: begin
        res_have         = 1'b1;
        res.data_valid   = 1'b1;
        res.data         = file_byte;
        res.packet_first = !hdr_latched && (bytes_left == captured_length);
        bytes_left_next  = bytes_left - 32'd1;
        if (bytes_left == 32'd1) begin
          res.packet_last = 1'b1;
          phase_next      = PH_RECHDR;
        end
      end
      default: begin
        phase_next = PH_REJECT;
      end
    endcase

    // Record summary on its last beat.
    if (res.packet_last) begin
      res.timestamp_us = seconds_us + {20'd0, microseconds};
      res.record_len   = {1'b0, captured_length} + (hdr_eff ? 33'd16 : 33'd0);
    end

    // End of file: report and return to the start state.
    if (file_end) begin
      res_have = 1'b1;
      if (phase_next == PH_REJECT) begin
        res.status = ST_NOT_PCAP;
      end else if (phase_next == PH_GLOBAL && header_count_next < MAGIC_LEN) begin
        res.status = ST_NOT_PCAP;
      end else if (phase_next == PH_RECHDR && header_count_next == '0) begin
        res.status = ST_CLEAN_END;
      end else begin
        res.status = ST_TRUNCATED;
      end
      phase_next           = PH_GLOBAL;
      header_count_next    = '0;
      seconds_next         = '0;
      microseconds_next    = '0;
      captured_length_next = '0;
      bytes_left_next      = '0;
      hdr_latched_next     = 1'b0;
    end
  end

  // Parser state, advanced once per accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_GLOBAL;
      header_count    <= '0;
      seconds         <= '0;
      microseconds    <= '0;
      captured_length <= '0;
      bytes_left      <= '0;
      hdr_latched     <= 1'b0;
    end else if (in_accept) begin
      phase           <= phase_next;
      header_count    <= header_count_next;
      seconds         <= seconds_next;
      microseconds    <= microseconds_next;
      captured_length <= captured_length_next;
      bytes_left      <= bytes_left_next;
      hdr_latched     <= hdr_latched_next;
    end
  end

endmodule

// File: rtl/prd_out_buf.sv
`timescale 1ns / 1ps

module prd_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  prd_pkg::result_t  push_data,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output prd_pkg::result_t  out_data
);
  import prd_pkg::*;

  logic    ob_valid;
  result_t ob;
  logic    sk_valid;
  result_t sk;
  logic    pop;

  assign pop       = ob_valid && out_ready;
  assign in_ready  = !sk_valid;
  assign out_valid = ob_valid;
  assign out_data  = ob;

  // Output register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      ob_valid <= 1'b0;
      sk_valid <= 1'b0;
    end else if (ob_valid && !pop) begin
      if (push) begin
        sk       <= push_data;
        sk_valid <= 1'b1;
      end
    end else if (sk_valid) begin
      ob       <= sk;
      ob_valid <= 1'b1;
      sk_valid <= 1'b0;
    end else if (push) begin
      ob       <= push_data;
      ob_valid <= 1'b1;
    end else begin
      ob_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/prd_checker.sv
`timescale 1ns / 1ps

module prd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  data,
  input logic        data_valid,
  input logic        packet_first,
  input logic        packet_last,
  input logic [51:0] timestamp_us,
  input logic [32:0] record_len,
  input logic [1:0]  status
);
  import prd_pkg::*;

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(data) && $stable(status)
      && $stable(packet_last) && $stable(record_len))
    else $error("stalled result beat changed");

  // Summary fields are zero except on the last beat of a record.
  a_summary_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !packet_last |-> timestamp_us == '0 && record_len == '0)
    else $error("summary fields set off the last beat");

  // A beat without a byte carries a zero data field.
  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !data_valid |-> data == '0)
    else $error("data set on a beat without a byte");

  // A byteless beat with no status can only be an empty record.
  a_empty_record: assert property (@(posedge clk) disable iff (rst)
    out_valid && !data_valid && status == ST_NONE
      |-> packet_first && packet_last && record_len == '0)
    else $error("byteless beat is neither status nor empty record");

endmodule

bind pcap_record_deframer prd_checker u_prd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .data         (data),
  .data_valid   (data_valid),
  .packet_first (packet_first),
  .packet_last  (packet_last),
  .timestamp_us (timestamp_us),
  .record_len   (record_len),
  .status       (status)
);

// File: tb/tb_pcap_record_deframer.sv
`timescale 1ns / 1ps

module tb_pcap_record_deframer;
  import prd_pkg::*;

  typedef logic [7:0] octet_t;

  typedef enum logic [1:0] {
    PARSE_FILE_HDR,
    PARSE_REC_HDR,
    PARSE_PAYLOAD,
    PARSE_REJECT
  } parse_phase_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  file_byte = 8'h00;
  logic        file_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  data;
  logic        data_valid;
  logic        packet_first;
  logic        packet_last;
  logic [51:0] timestamp_us;
  logic [32:0] record_len;
  logic [1:0]  status;

  // Traffic shaping knobs and bookkeeping.
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  logic    rx_hold = 1'b0;
  int      error_count = 0;
  int      beats_sent = 0;
  result_t expected_beats[$];
  result_t want_beat;

  // Parser state mirrored by the predictor.
  logic         include_hdr = 1'b0;
  parse_phase_t parse_phase = PARSE_FILE_HDR;
  logic [4:0]   hdr_count = '0;
  logic [31:0]  rec_sec = '0;
  logic [31:0]  rec_usec = '0;
  logic [31:0]  rec_caplen = '0;
  logic [31:0]  payload_left = '0;
  logic         hdr_forwarded = 1'b0;

  pcap_record_deframer u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .file_byte    (file_byte),
    .file_end     (file_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .data         (data),
    .data_valid   (data_valid),
    .packet_first (packet_first),
    .packet_last  (packet_last),
    .timestamp_us (timestamp_us),
    .record_len   (record_len),
    .status       (status)
  );

  always #5 clk = ~clk;

  // Work out the result beat, if any, that one accepted file byte causes.
  task automatic predict_deframe(input octet_t b, input logic last_byte);
    result_t r;
    logic    emit;
    r = '0;
    r.status = ST_NONE;
    emit = 1'b0;
    case (parse_phase)
      PARSE_FILE_HDR: begin
        if (hdr_count < MAGIC_LEN && b != MAGIC[hdr_count[1:0]]) begin
          parse_phase = PARSE_REJECT;
        end else begin
          hdr_count++;
          if (hdr_count >= GLOBAL_HDR_LEN) begin
            parse_phase = PARSE_REC_HDR;
            hdr_count = '0;
          end
        end
      end
      PARSE_REC_HDR: begin
        // The header option is latched at the first header byte of a record.
        if (hdr_count == 0) begin
          hdr_forwarded = include_hdr;
          rec_sec = '0;
          rec_usec = '0;
          rec_caplen = '0;
        end
        case (hdr_count[3:2])
          2'd0: rec_sec[8*hdr_count[1:0] +: 8] = b;
          2'd1: rec_usec[8*hdr_count[1:0] +: 8] = b;
          2'd2: rec_caplen[8*hdr_count[1:0] +: 8] = b;
          default: ;
        endcase
        hdr_count++;
        if (hdr_forwarded) begin
          emit = 1'b1;
          r.data_valid = 1'b1;
          r.data = b;
          r.packet_first = (hdr_count == 1);
        end
        if (hdr_count >= RECORD_HDR_LEN) begin
          hdr_count = '0;
          if (rec_caplen == 0) begin
            // An empty record still closes with a packet_last beat.
            emit = 1'b1;
            r.packet_last = 1'b1;
            if (!hdr_forwarded) r.packet_first = 1'b1;
          end else begin
            parse_phase = PARSE_PAYLOAD;
            payload_left = rec_caplen;
          end
        end
      end
      PARSE_PAYLOAD: begin
        emit = 1'b1;
        r.data_valid = 1'b1;
        r.data = b;
        r.packet_first = !hdr_forwarded && (payload_left == rec_caplen);
        payload_left--;
        if (payload_left == 0) begin
          r.packet_last = 1'b1;
          parse_phase = PARSE_REC_HDR;
        end
      end
      default: parse_phase = PARSE_REJECT;
    endcase

    if (r.packet_last) begin
      r.timestamp_us = 52'(64'(rec_sec) * 64'(USEC_PER_SEC) + 64'(rec_usec));
      r.record_len = 33'(rec_caplen) + (hdr_forwarded ? 33'(RECORD_HDR_LEN) : 33'd0);
    end

    // The final byte of a file always carries the end status and rewinds the parser.
    if (last_byte) begin
      if (parse_phase == PARSE_REJECT) r.status = ST_NOT_PCAP;
      else if (parse_phase == PARSE_FILE_HDR && hdr_count < MAGIC_LEN) r.status = ST_NOT_PCAP;
      else if (parse_phase == PARSE_REC_HDR && hdr_count == 0) r.status = ST_CLEAN_END;
      else r.status = ST_TRUNCATED;
      emit = 1'b1;
      parse_phase = PARSE_FILE_HDR;
      hdr_count = '0;
      rec_sec = '0;
      rec_usec = '0;
      rec_caplen = '0;
      payload_left = '0;
      hdr_forwarded = 1'b0;
    end

    if (emit) expected_beats.push_back(r);
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endfunction

  // Output side: choose out_ready each cycle and check every accepted beat.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected: data %0h status %0d", data, status);
        error_count++;
      end else begin
        want_beat = expected_beats.pop_front();
        check_field("data", 64'(want_beat.data), 64'(data));
        check_field("data_valid", 64'(want_beat.data_valid), 64'(data_valid));
        check_field("packet_first", 64'(want_beat.packet_first), 64'(packet_first));
        check_field("packet_last", 64'(want_beat.packet_last), 64'(packet_last));
        check_field("timestamp_us", 64'(want_beat.timestamp_us), 64'(timestamp_us));
        check_field("record_len", 64'(want_beat.record_len), 64'(record_len));
        check_field("status", 64'(want_beat.status), 64'(status));
      end
    end
    out_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // Offer one file byte, with a random gap first, and wait until it is taken.
  task automatic send_beat(input octet_t b, input logic last_byte);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    file_byte <= b;
    file_end <= last_byte;
    do @(posedge clk); while (!in_ready);
    predict_deframe(b, last_byte);
    beats_sent++;
  endtask

  task automatic send_file(input octet_t q[$]);
    for (int i = 0; i < q.size(); i++) send_beat(q[i], i == q.size() - 1);
  endtask

  // Stop offering input and let every expected beat drain out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_include_header(input logic v);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    include_hdr = v;
  endtask

  // Hold the output off for the number of cycles given by the argument.
  task automatic hold_receiver(input int cycles);
    rx_hold <= 1'b1;
    repeat (cycles) @(posedge clk);
    rx_hold <= 1'b0;
  endtask

  // File image builders; all multi-byte fields are little-endian.
  task automatic push_word(ref octet_t q[$], input logic [31:0] w);
    for (int i = 0; i < 4; i++) q.push_back(w[8*i +: 8]);
  endtask

  task automatic push_file_header(ref octet_t q[$]);
    for (int i = 0; i < 4; i++) q.push_back(MAGIC[i]);
    repeat (20) q.push_back(octet_t'($urandom_range(255)));
  endtask

  task automatic push_record(ref octet_t q[$], input logic [31:0] sec,
                             input logic [31:0] usec, input logic [31:0] caplen,
                             input int n_data);
    push_word(q, sec);
    push_word(q, usec);
    push_word(q, caplen);
    push_word(q, $urandom());
    repeat (n_data) q.push_back(octet_t'($urandom_range(255)));
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // Mostly short packets, some empty ones and a few long ones.
  function automatic int pick_caplen();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 94) return $urandom_range(1, 24);
    return $urandom_range(100, 300);
  endfunction

  // Mostly well-formed files with random content, the rest broken or noise.
  task automatic build_random_file(ref octet_t q[$]);
    int     kind;
    int     n;
    int     len;
    octet_t bad;
    q.delete();
    kind = $urandom_range(99);
    if (kind < 82) begin
      push_file_header(q);
      n = $urandom_range(1, 4);
      repeat (n) begin
        len = pick_caplen();
        push_record(q, pick_word(), pick_word(), len, len);
      end
      // Cut some files short at an arbitrary point.
      if (kind >= 72) begin
        n = $urandom_range(1, q.size() - 1);
        while (q.size() > n) void'(q.pop_back());
      end
    end else if (kind < 88) begin
      // Huge captured length, so the file always ends inside the packet.
      push_file_header(q);
      push_record(q, pick_word(), pick_word(), $urandom() | 32'h0000_0100,
                  $urandom_range(0, 8));
    end else if (kind < 95) begin
      n = $urandom_range(3);
      for (int i = 0; i < n; i++) q.push_back(MAGIC[i]);
      do bad = octet_t'($urandom_range(255)); while (bad == MAGIC[n]);
      q.push_back(bad);
      repeat ($urandom_range(0, 6)) q.push_back(octet_t'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(1, 30)) q.push_back(octet_t'($urandom_range(255)));
    end
  endtask

  // Plain records: data only, including the largest timestamp and an empty record.
  task automatic test_clean_records();
    octet_t f[$];
    write_include_header(1'b0);
    push_file_header(f);
    push_record(f, 32'h0000_0001, 32'h0000_0002, 1, 1);
    push_record(f, 32'hffff_ffff, 32'hffff_ffff, 3, 3);
    push_record(f, 32'h1234_5678, 32'h0000_0000, 0, 0);
    send_file(f);
    wait_idle();
  endtask

  // Record headers forwarded ahead of the packet bytes.
  task automatic test_forwarded_header();
    octet_t f[$];
    write_include_header(1'b1);
    push_file_header(f);
    push_record(f, 32'h89ab_cdef, 32'h000f_423f, 2, 2);
    push_record(f, 32'h0000_0000, 32'hffff_ffff, 0, 0);
    send_file(f);
    write_include_header(1'b0);
  endtask

  // Wrong magic at each position, and files too short to hold the magic.
  task automatic test_bad_magic();
    octet_t f[$];
    for (int k = 0; k < 4; k++) begin
      f.delete();
      for (int i = 0; i < k; i++) f.push_back(MAGIC[i]);
      f.push_back(~MAGIC[k]);
      f.push_back(octet_t'($urandom_range(255)));
      f.push_back(MAGIC[0]);
      send_file(f);
    end
    f.delete();
    f.push_back(MAGIC[0]);
    send_file(f);
    f.delete();
    for (int i = 0; i < 3; i++) f.push_back(MAGIC[i]);
    send_file(f);
    wait_idle();
  endtask

  // Files that stop in the global header, a record header or the packet data.
  task automatic test_truncation();
    octet_t f[$];
    f.delete();
    for (int i = 0; i < 4; i++) f.push_back(MAGIC[i]);
    send_file(f);
    f.delete();
    push_file_header(f);
    while (f.size() > 10) void'(f.pop_back());
    send_file(f);
    f.delete();
    push_file_header(f);
    push_record(f, 32'h0000_0010, 32'h0000_0020, 4, 0);
    while (f.size() > 24 + 7) void'(f.pop_back());
    send_file(f);
    f.delete();
    push_file_header(f);
    push_record(f, 32'h0000_0010, 32'h0000_0020, 5, 0);
    send_file(f);
    write_include_header(1'b1);
    f.delete();
    push_file_header(f);
    push_record(f, 32'h0000_0003, 32'h0000_0004, 5, 2);
    send_file(f);
    f.delete();
    push_file_header(f);
    push_record(f, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 3);
    send_file(f);
    write_include_header(1'b0);
  endtask

  // Output held off for a long stretch while input keeps coming.
  task automatic test_backpressure();
    octet_t f[$];
    send_idle_pct = 0;
    recv_stall_pct = 0;
    push_file_header(f);
    push_record(f, pick_word(), pick_word(), 200, 200);
    push_record(f, pick_word(), pick_word(), 20, 20);
    fork
      hold_receiver(300);
      send_file(f);
    join
    wait_idle();
  endtask

  // Random files under one idling profile, with the header option set at random between files.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int n_bytes);
    octet_t f[$];
    int     start;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = beats_sent;
    while (beats_sent - start < n_bytes) begin
      if ($urandom_range(3) == 0) write_include_header(1'($urandom_range(1)));
      build_random_file(f);
      send_file(f);
    end
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_clean_records();
    test_forwarded_header();
    test_bad_magic();
    test_truncation();
    test_backpressure();
    test_random_traffic(0, 0, 250);
    test_random_traffic(75, 0, 250);
    test_random_traffic(0, 75, 250);
    test_random_traffic(38, 38, 250);
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_beats.size() == 0) begin
      $display("end of test: clean");
    end else begin
      if (expected_beats.size() != 0)
        $error("%0d expected result beats never arrived", expected_beats.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
